[rtl/rrp_pkg.sv]
package rrp_pkg;

  // Fixed field widths of the streams
  localparam int OP_W            = 2;
  localparam int DESC_W          = 6;
  localparam int MASK_W          = 64;
  localparam int STAT_W          = 2;
  localparam int CNT_W           = 7;
  localparam int IN_TDATA_W      = 72;
  localparam int OUT_TDATA_W     = 24;

  // Positions examined per scan cycle
  localparam int SCAN_W          = 16;

  localparam int DESCRIPTORS_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOAD   = 2'd2,
    OP_PICK   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    SK_DOWN,
    SK_UP,
    SK_COUNT,
    SK_PICK
  } scan_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_EXEC,
    DP_STEP,
    DP_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic scan;   // exec needs scan cycles
    logic done;   // scan finishes this cycle
  } dp_sts_t;

endpackage

[rtl/rrp_ctrl.sv]
module rrp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             out_tready,
  output logic             out_tvalid,
  output rrp_pkg::dp_cmd_t cmd,
  input  rrp_pkg::dp_sts_t sts
);
  import rrp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = sts.scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (sts.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = DP_NOP;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd = DP_CAPTURE;
      end
      S_EXEC: cmd = DP_EXEC;
      S_SCAN: cmd = DP_STEP;
      S_DONE: begin
        if (slot_free) begin
          cmd           = DP_EMIT;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/rrp_datapath.sv]
module rrp_datapath #(
  parameter int DESCRIPTORS = rrp_pkg::DESCRIPTORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rrp_pkg::dp_cmd_t           cmd,
  output rrp_pkg::dp_sts_t           sts,
  input  logic [rrp_pkg::OP_W-1:0]   in_op,
  input  logic [rrp_pkg::DESC_W-1:0] in_desc,
  input  logic [rrp_pkg::MASK_W-1:0] in_mask,
  output logic [rrp_pkg::STAT_W-1:0] out_status,
  output logic [rrp_pkg::DESC_W-1:0] out_picked,
  output logic [rrp_pkg::CNT_W-1:0]  out_members,
  output logic [rrp_pkg::CNT_W-1:0]  out_scan_limit
);
  import rrp_pkg::*;

  localparam int IDX_W = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
  localparam int SUM_W = IDX_W + $clog2(SCAN_W) + 1;

  // Architectural state
  logic [DESCRIPTORS-1:0] pool_r, pool_nxt;
  logic [DESCRIPTORS-1:0] ready_r, ready_nxt;
  logic [IDX_W-1:0]       low_r, low_nxt;
  logic [IDX_W-1:0]       high_r, high_nxt;
  logic [IDX_W-1:0]       last_r, last_nxt;
  logic [CNT_W-1:0]       members_r, members_nxt;
  logic [CNT_W-1:0]       remain_r, remain_nxt;

  // Per-transaction working registers
  op_t                    op_r, op_nxt;
  logic [DESC_W-1:0]      desc_r, desc_nxt;
  scan_kind_t             kind_r, kind_nxt;
  logic [IDX_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]       left_r, left_nxt;
  stat_t                  status_r, status_nxt;
  logic [IDX_W-1:0]       picked_r, picked_nxt;

  // Output register
  logic [STAT_W-1:0]      ostat_r, ostat_nxt;
  logic [DESC_W-1:0]      opick_r, opick_nxt;
  logic [CNT_W-1:0]       omem_r, omem_nxt;
  logic [CNT_W-1:0]       olim_r, olim_nxt;

  assign out_status     = ostat_r;
  assign out_picked     = opick_r;
  assign out_members    = omem_r;
  assign out_scan_limit = olim_r;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] p,
                                                 input logic [IDX_W-1:0] lo,
                                                 input logic [IDX_W-1:0] hi);
    logic [IDX_W-1:0] r;
    r = p;
    if (p > hi) r = hi;
    else if (p < lo) r = lo;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] adv_idx(input logic [IDX_W-1:0] p,
                                               input logic [IDX_W-1:0] lo,
                                               input logic [IDX_W-1:0] hi);
    logic [IDX_W-1:0] r;
    r = (p >= hi) ? lo : p + IDX_W'(1);
    return r;
  endfunction

  // Circular position inside [lo, hi]; at most one wrap for the offsets used
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s,
                                                input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi);
    logic [SUM_W-1:0] r;
    r = s;
    if (s > SUM_W'(hi)) r = SUM_W'(lo) + s - SUM_W'(hi) - SUM_W'(1);
    return r[IDX_W-1:0];
  endfunction

  // Decoded fields of the held transaction
  logic             d_ok;
  logic [IDX_W-1:0] d_idx;
  logic             is_member;

  assign d_ok      = {1'b0, desc_r} < CNT_W'(DESCRIPTORS);
  assign d_idx     = desc_r[IDX_W-1:0];
  assign is_member = d_ok && pool_r[d_idx];

  // One scan window of SCAN_W positions
  logic             dn_hit, up_hit, pk_hit;
  logic [IDX_W-1:0] dn_idx, up_idx, pk_idx;
  logic [CNT_W-1:0] win_cnt;
  logic [IDX_W-1:0] pk_next;
  logic             last_win;

  always_comb begin
    logic [SUM_W-1:0] s;
    logic [IDX_W-1:0] p;
    s       = '0;
    p       = '0;
    dn_hit  = 1'b0;
    up_hit  = 1'b0;
    pk_hit  = 1'b0;
    dn_idx  = '0;
    up_idx  = '0;
    pk_idx  = '0;
    win_cnt = '0;
    for (int k = 0; k < SCAN_W; k++) begin
      // downward from pos
      if (!dn_hit && (SUM_W'(pos_r) >= SUM_W'(k))) begin
        s = SUM_W'(pos_r) - SUM_W'(k);
        if (pool_r[s[IDX_W-1:0]]) begin
          dn_hit = 1'b1;
          dn_idx = s[IDX_W-1:0];
        end
      end
      // upward from pos, also the popcount window
      s = SUM_W'(pos_r) + SUM_W'(k);
      if (s < SUM_W'(DESCRIPTORS)) begin
        if (!up_hit && pool_r[s[IDX_W-1:0]]) begin
          up_hit = 1'b1;
          up_idx = s[IDX_W-1:0];
        end
        win_cnt = win_cnt + CNT_W'(ready_r[s[IDX_W-1:0]]);
      end
      // circular pick window
      if (CNT_W'(k) < left_r) begin
        p = wrap_idx(s, low_r, high_r);
        if (!pk_hit && ready_r[p]) begin
          pk_hit = 1'b1;
          pk_idx = p;
        end
      end
    end
    pk_next  = wrap_idx(SUM_W'(pos_r) + SUM_W'(SCAN_W), low_r, high_r);
    last_win = (SUM_W'(pos_r) + SUM_W'(SCAN_W)) >= SUM_W'(DESCRIPTORS);
  end

  always_comb begin
    pool_nxt    = pool_r;
    ready_nxt   = ready_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    last_nxt    = last_r;
    members_nxt = members_r;
    remain_nxt  = remain_r;
    op_nxt      = op_r;
    desc_nxt    = desc_r;
    kind_nxt    = kind_r;
    pos_nxt     = pos_r;
    left_nxt    = left_r;
    status_nxt  = status_r;
    picked_nxt  = picked_r;
    ostat_nxt   = ostat_r;
    opick_nxt   = opick_r;
    omem_nxt    = omem_r;
    olim_nxt    = olim_r;
    sts         = '0;

    case (cmd)
      DP_CAPTURE: begin
        op_nxt   = op_t'(in_op);
        desc_nxt = in_desc;
        if (op_t'(in_op) == OP_LOAD) begin
          ready_nxt  = in_mask[DESCRIPTORS-1:0] & pool_r;
          remain_nxt = '0;
        end
      end

      DP_EXEC: begin
        status_nxt = ST_OK;
        picked_nxt = '0;
        case (op_r)
          OP_ADD: begin
            if (!d_ok || is_member) begin
              status_nxt = ST_REJECT;
            end else begin
              pool_nxt[d_idx] = 1'b1;
              members_nxt     = members_r + CNT_W'(1);
              if (members_r == '0) begin
                low_nxt  = d_idx;
                high_nxt = d_idx;
              end else begin
                low_nxt  = (d_idx < low_r) ? d_idx : low_r;
                high_nxt = (d_idx > high_r) ? d_idx : high_r;
              end
              last_nxt = clamp_idx(last_r, low_nxt, high_nxt);
            end
          end
          OP_REMOVE: begin
            if (!d_ok || !is_member) begin
              status_nxt = ST_REJECT;
            end else begin
              pool_nxt[d_idx] = 1'b0;
              if (ready_r[d_idx]) begin
                ready_nxt[d_idx] = 1'b0;
                if (remain_r != '0) remain_nxt = remain_r - CNT_W'(1);
              end
              members_nxt = members_r - CNT_W'(1);
              // a sole member leaves the bounds collapsed where they are
              if (members_r != CNT_W'(1)) begin
                if (d_idx == high_r) begin
                  kind_nxt = SK_DOWN;
                  pos_nxt  = high_r - IDX_W'(1);
                  sts.scan = 1'b1;
                end else if (d_idx == low_r) begin
                  kind_nxt = SK_UP;
                  pos_nxt  = low_r + IDX_W'(1);
                  sts.scan = 1'b1;
                end
              end
            end
          end
          OP_LOAD: begin
            kind_nxt = SK_COUNT;
            pos_nxt  = '0;
            sts.scan = 1'b1;
          end
          OP_PICK: begin
            if (remain_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              kind_nxt = SK_PICK;
              pos_nxt  = adv_idx(last_r, low_r, high_r);
              left_nxt = CNT_W'(high_r) - CNT_W'(low_r) + CNT_W'(1);
              sts.scan = 1'b1;
            end
          end
          default: status_nxt = ST_OK;
        endcase
      end

      DP_STEP: begin
        case (kind_r)
          SK_DOWN: begin
            if (dn_hit) begin
              high_nxt = dn_idx;
              last_nxt = clamp_idx(last_r, low_r, dn_idx);
              sts.done = 1'b1;
            end else if (SUM_W'(pos_r) < SUM_W'(SCAN_W)) begin
              sts.done = 1'b1;
            end else begin
              pos_nxt = pos_r - IDX_W'(SCAN_W);
            end
          end
          SK_UP: begin
            if (up_hit) begin
              low_nxt  = up_idx;
              last_nxt = clamp_idx(last_r, up_idx, high_r);
              sts.done = 1'b1;
            end else if (last_win) begin
              sts.done = 1'b1;
            end else begin
              pos_nxt = pos_r + IDX_W'(SCAN_W);
            end
          end
          SK_COUNT: begin
            remain_nxt = remain_r + win_cnt;
            if (last_win) sts.done = 1'b1;
            else pos_nxt = pos_r + IDX_W'(SCAN_W);
          end
          SK_PICK: begin
            if (pk_hit) begin
              ready_nxt[pk_idx] = 1'b0;
              last_nxt          = pk_idx;
              remain_nxt        = remain_r - CNT_W'(1);
              picked_nxt        = pk_idx;
              status_nxt        = ST_OK;
              sts.done          = 1'b1;
            end else if (left_r <= CNT_W'(SCAN_W)) begin
              // whole ring seen without a ready bit: step the pointer once
              last_nxt   = adv_idx(last_r, low_r, high_r);
              status_nxt = ST_EMPTY;
              sts.done   = 1'b1;
            end else begin
              pos_nxt  = pk_next;
              left_nxt = left_r - CNT_W'(SCAN_W);
            end
          end
          default: sts.done = 1'b1;
        endcase
      end

      DP_EMIT: begin
        ostat_nxt = status_r;
        opick_nxt = DESC_W'(picked_r);
        omem_nxt  = members_r;
        olim_nxt  = CNT_W'(high_r) + CNT_W'(1);
      end

      default: sts = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r    <= '0;
      ready_r   <= '0;
      low_r     <= '0;
      high_r    <= '0;
      last_r    <= '0;
      members_r <= '0;
      remain_r  <= '0;
      kind_r    <= SK_DOWN;
      status_r  <= ST_OK;
    end else begin
      pool_r    <= pool_nxt;
      ready_r   <= ready_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      last_r    <= last_nxt;
      members_r <= members_nxt;
      remain_r  <= remain_nxt;
      kind_r    <= kind_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    desc_r   <= desc_nxt;
    pos_r    <= pos_nxt;
    left_r   <= left_nxt;
    picked_r <= picked_nxt;
    ostat_r  <= ostat_nxt;
    opick_r  <= opick_nxt;
    omem_r   <= omem_nxt;
    olim_r   <= olim_nxt;
  end

endmodule

[rtl/round_robin_ready_picker.sv]
// Channel  Dir  tdata (low bit up)                         tuser
// -------  ---  -----------------------------------------  -----------
// in_      in   descriptor[5:0], ready_mask[69:6], 0 pad   op[1:0]
// out_     out  picked[5:0], members[12:6],                status[1:0]
//               scan_limit[19:13], 0 pad
//
// One transaction at a time: accept, execute, scan when needed, then load
// the output register. Add, reject, remove of an inner member and empty
// pick need no scan. Load scans all DESCRIPTORS positions. Pick, and a
// remove of a bound member, scan at most span = highest - lowest + 1
// positions, fewer when the scan hits early; the datapath examines a
// 16-position scan window per scan step.
// Reset clears the maps, bounds, pointer and counts.
// A new input is taken while a result still waits in the output register;
// a result waits for out_tready before the next one is produced.
module round_robin_ready_picker #(
  parameter int DESCRIPTORS = rrp_pkg::DESCRIPTORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rrp_pkg::IN_TDATA_W-1:0]  in_tdata,   // descriptor, ready_mask
  input  logic [rrp_pkg::OP_W-1:0]        in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rrp_pkg::OUT_TDATA_W-1:0] out_tdata,  // picked, members, scan_limit
  output logic [rrp_pkg::STAT_W-1:0]      out_tuser   // status
);
  import rrp_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [DESC_W-1:0] picked;
  logic [CNT_W-1:0]  members;
  logic [CNT_W-1:0]  scan_limit;

  rrp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  rrp_datapath #(
    .DESCRIPTORS (DESCRIPTORS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_tuser),
    .in_desc        (in_tdata[DESC_W-1:0]),
    .in_mask        (in_tdata[DESC_W+MASK_W-1:DESC_W]),
    .out_status     (out_tuser),
    .out_picked     (picked),
    .out_members    (members),
    .out_scan_limit (scan_limit)
  );

  assign out_tdata = {(OUT_TDATA_W-DESC_W-2*CNT_W)'(0), scan_limit, members, picked};

endmodule

[bench/tb_top.sv]
module tb_top;
  import rrp_pkg::*;

  localparam int N_ITEMS   = 1400;
  localparam int HOLD_AT   = 300;   // result count at which the sink holds off
  localparam int HOLD_LEN  = 400;
  localparam int IDLE_MAX  = 3000;
  localparam int DRAIN_CYC = 20;

  typedef struct {
    op_t         op;
    logic [5:0]  desc;
    logic [63:0] mask;
    bit          drain;   // wait for all replies before offering this one
  } pick_req_t;

  typedef struct {
    stat_t      status;
    logic [5:0] picked;
    logic [6:0] members;
    logic [6:0] scan_limit;
  } pick_reply_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  pick_req_t   op_queue[$];
  pick_reply_t pending_replies[$];
  pick_req_t   drv_req;
  int          drv_gap;
  int          rx_stall;
  int          idle_cycles = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_err = 0;

  // Shadow of the picker state
  logic [63:0] pool_bits;
  logic [63:0] ready_bits;
  int unsigned low_b;
  int unsigned high_b;
  int unsigned ptr;
  int unsigned n_members;
  int unsigned n_ready;

  round_robin_ready_picker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned step_ptr(int unsigned p);
    return (p + 1 > high_b) ? low_b : p + 1;
  endfunction

  function automatic void clamp_ptr();
    if (ptr > high_b) ptr = high_b;
    else if (ptr < low_b) ptr = low_b;
  endfunction

  function automatic void raise_low();
    while (!pool_bits[low_b] && low_b < high_b) low_b++;
  endfunction

  function automatic void drop_high();
    while (!pool_bits[high_b] && high_b > low_b) high_b--;
  endfunction

  function automatic pick_reply_t apply_picker_op(pick_req_t r);
    pick_reply_t rep;
    int unsigned j;
    bit          found;
    rep.status = ST_OK;
    rep.picked = '0;
    found      = 1'b0;
    case (r.op)
      OP_ADD: begin
        if (pool_bits[r.desc]) begin
          rep.status = ST_REJECT;
        end else begin
          pool_bits[r.desc] = 1'b1;
          n_members++;
          if (r.desc > high_b) begin
            high_b = 32'(r.desc);
            raise_low();
          end
          if (r.desc < low_b) begin
            low_b = 32'(r.desc);
            drop_high();
          end
          clamp_ptr();
        end
      end
      OP_REMOVE: begin
        if (!pool_bits[r.desc]) begin
          rep.status = ST_REJECT;
        end else begin
          pool_bits[r.desc] = 1'b0;
          if (ready_bits[r.desc]) begin
            ready_bits[r.desc] = 1'b0;
            if (n_ready > 0) n_ready--;
          end
          if (n_members > 0) n_members--;
          drop_high();
          raise_low();
          clamp_ptr();
        end
      end
      OP_LOAD: begin
        ready_bits = r.mask & pool_bits;
        n_ready    = $countones(ready_bits);
      end
      default: begin
        if (n_ready > 0) begin
          // circular scan from the slot after the pointer, back to the pointer
          j = step_ptr(ptr);
          for (int g = 0; g < 65; g++) begin
            if (ready_bits[j]) begin
              found = 1'b1;
              break;
            end
            if (j == ptr) break;
            j = step_ptr(j);
          end
          if (found) begin
            ready_bits[j] = 1'b0;
            ptr           = j;
            n_ready--;
            rep.picked    = 6'(j);
          end else begin
            ptr = step_ptr(ptr);
          end
        end
        if (!found) rep.status = ST_EMPTY;
      end
    endcase
    rep.members    = 7'(n_members);
    rep.scan_limit = 7'(high_b + 1);
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_err++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Some stretches run with no idle cycles at all
  function automatic int draw_gap(int k);
    if ((k / 150) % 4 == 1) return 0;
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return {$urandom, $urandom} & {$urandom, $urandom};
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [5:0] in_window(int base, int span);
    return 6'(base + $urandom_range(0, span - 1));
  endfunction

  function automatic void push_op(op_t op, logic [5:0] d, logic [63:0] m, bit drain = 1'b0);
    pick_req_t r;
    r.op    = op;
    r.desc  = d;
    r.mask  = m;
    r.drain = drain;
    op_queue.push_back(r);
  endfunction

  // Source side
  always @(posedge clk) begin : driver
    bit offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      drv_gap = 0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        pending_replies.push_back(apply_picker_op(drv_req));
        n_sent++;
        offer = 1'b0;
      end
      if (!offer && op_queue.size() != 0) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (!op_queue[0].drain || n_sent == n_got) begin
          drv_req = op_queue.pop_front();
          in_tdata <= {2'b00, drv_req.mask, drv_req.desc};
          in_tuser <= drv_req.op;
          offer = 1'b1;
          drv_gap = draw_gap(n_sent);
        end
      end
      in_tvalid <= offer;
    end
  end

  // Sink side and result check
  always @(posedge clk) begin : receiver
    bit          take;
    pick_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      take = out_tready;
      if (out_tvalid && out_tready) begin
        if (pending_replies.size() == 0) begin
          n_err++;
          $display("%0t: unexpected transaction: expected none, actual status %0d tdata %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = pending_replies.pop_front();
          check_field("status", int'(want.status), 32'(out_tuser));
          check_field("picked", 32'(want.picked), 32'(out_tdata[5:0]));
          check_field("members", 32'(want.members), 32'(out_tdata[12:6]));
          check_field("scan_limit", 32'(want.scan_limit), 32'(out_tdata[19:13]));
        end
        n_got <= n_got + 1;
        take = 1'b0;
        rx_stall = (n_got + 1 == HOLD_AT) ? HOLD_LEN : draw_gap(n_got);
      end
      if (!take) begin
        if (rx_stall > 0) rx_stall--;
        else take = 1'b1;
      end
      out_tready <= take;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_MAX) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int base;
    int span;
    int round;
    op_t any_op;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_ADD;
    out_tready = 1'b0;
    rst_n      = 1'b0;
    pool_bits  = '0;
    ready_bits = '0;
    low_b      = 0;
    high_b     = 0;
    ptr        = 0;
    n_members  = 0;
    n_ready    = 0;

    // Directed: empty pool, duplicates, bounds at both ends, ready removal
    push_op(OP_PICK, 6'd0, '0);
    push_op(OP_REMOVE, 6'd0, '0);
    push_op(OP_LOAD, 6'd0, '1);
    push_op(OP_ADD, 6'd0, '0);
    push_op(OP_ADD, 6'd0, '1);
    push_op(OP_ADD, 6'd63, '0);
    push_op(OP_ADD, 6'd31, '0);
    push_op(OP_LOAD, 6'd63, '1);
    push_op(OP_PICK, 6'd0, '0);
    push_op(OP_PICK, 6'd0, '0);
    push_op(OP_PICK, 6'd0, '0);
    push_op(OP_PICK, 6'd0, '0);
    push_op(OP_LOAD, 6'd0, '1);
    push_op(OP_REMOVE, 6'd31, '0);
    push_op(OP_PICK, 6'd63, '1);
    push_op(OP_REMOVE, 6'd63, '0);
    push_op(OP_REMOVE, 6'd0, '0);
    push_op(OP_REMOVE, 6'd0, '0);
    push_op(OP_PICK, 6'd0, '0);
    push_op(OP_ADD, 6'd63, '0);
    push_op(OP_ADD, 6'd62, '0);
    push_op(OP_LOAD, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    push_op(OP_PICK, 6'd0, '0);
    push_op(OP_LOAD, 6'd0, 64'h5555_5555_5555_5555);
    push_op(OP_PICK, 6'd0, '0);

    // Random rounds: fill a window, load, pick past empty, thin out, noise
    round = 0;
    while (op_queue.size() < N_ITEMS) begin
      round++;
      base = $urandom_range(0, 63);
      case ($urandom_range(0, 4))
        0: span = 1;
        1: span = 4;
        2: span = 8;
        3: span = 16;
        default: span = 64;
      endcase
      push_op(OP_ADD, in_window(base, span), rand_mask(), round % 8 == 0);
      repeat ($urandom_range(0, 11)) push_op(OP_ADD, in_window(base, span), rand_mask());
      push_op(OP_LOAD, 6'($urandom), rand_mask());
      repeat ($urandom_range(1, 20)) push_op(OP_PICK, 6'($urandom), rand_mask());
      if (span <= 16 && $urandom_range(0, 5) == 0) begin
        for (int k = 0; k < span; k++) push_op(OP_REMOVE, 6'(base + k), rand_mask());
      end else begin
        repeat ($urandom_range(0, 10)) push_op(OP_REMOVE, in_window(base, span), rand_mask());
      end
      repeat ($urandom_range(0, 3)) begin
        any_op = op_t'($urandom_range(0, 3));
        push_op(any_op, 6'($urandom), rand_mask());
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_tvalid || n_sent != n_got) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (pending_replies.size() != 0) begin
      n_err++;
      $display("%0t: missing results: expected %0d more, actual 0",
               $time, pending_replies.size());
    end
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
